// File: hw/rtl/repc_pkg.sv
// ----------------------------------------------------------------------------
// repc_pkg: shared types for the range equal-pair counter
// Holds the sequencer state encoding and the gcd unit control bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package repc_pkg;

  localparam int unsigned OUT_W = 19;
  localparam int unsigned NUM_W = 20;

  // one-hot sequencer states
  typedef enum logic [10:0] {
    ST_IDLE  = 11'b00000000001,
    ST_LOAD  = 11'b00000000010,
    ST_LRD   = 11'b00000000100,
    ST_LUPD  = 11'b00000001000,
    ST_PLAN  = 11'b00000010000,
    ST_RD    = 11'b00000100000,
    ST_CNT   = 11'b00001000000,
    ST_UPD   = 11'b00010000000,
    ST_GCD   = 11'b00100000000,
    ST_DIV   = 11'b01000000000,
    ST_CLR   = 11'b10000000000
  } state_t;

  // control bundle toward the gcd unit
  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] a;
    logic [NUM_W-1:0] b;
  } gcd_req_t;

  typedef struct packed {
    logic             done;
    logic [NUM_W-1:0] g;
  } gcd_rsp_t;

endpackage

`default_nettype wire

// File: hw/rtl/range_equal_pair_counter.sv
// ----------------------------------------------------------------------------
// range_equal_pair_counter: equal-colour pair fraction over array ranges
// Sliding-window histogram with a serial gcd and divide for reduction.
// ----------------------------------------------------------------------------
// Usage: pulse start with in_action 0 to load in_colour at in_position, or
// in_action 1 to query [in_range_left, in_range_right]. An item is taken when
// start is high and busy low. A load gives no result; one outside the window
// is written straight into the colour store without raising busy, one inside
// it holds busy while the old colour is counted out and the new one in. A
// query gives one result on out_* marked by out_valid for one cycle. Error
// and single-element queries answer in the cycle after acceptance and never
// raise busy. Other queries hold busy while the window moves one position at
// a time (plan, colour read, count read, count update; the first two positions
// of a fill into an empty window skip the plan), then through a final plan,
// the Euclid remainder steps in the gcd unit and the final divide; the result
// strobes in the first cycle busy is low. Reset clears the window and starts
// a clearing pass over the count memory, one entry per cycle, so busy stays
// high after reset until all COLOURS entries (1024 by default) are cleared.
// The receiver cannot stall: results must be taken in the cycle they appear.
// ----------------------------------------------------------------------------
`default_nettype none

module range_equal_pair_counter #(
  parameter int unsigned DEPTH   = 1024,
  parameter int unsigned COLOURS = 1024
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        in_action,
  input  wire logic [9:0]  in_position,
  input  wire logic [9:0]  in_colour,
  input  wire logic [9:0]  in_range_left,
  input  wire logic [9:0]  in_range_right,
  output logic             out_valid,
  output logic [18:0]      out_numerator,
  output logic [18:0]      out_denominator,
  output logic             out_range_error
);
  import repc_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = (COLOURS > 1) ? $clog2(COLOURS) : 1;
  localparam int unsigned KW = AW + 1;
  localparam int unsigned PW = 2 * AW + 1;

  state_t           st_r, st_nxt;
  logic [AW-1:0]    wlo_r, whi_r, ql_r, qr_r, pos_r, lpos_r;
  logic             wempty_r;
  logic [PW-1:0]    pairs_r;
  logic [CW-1:0]    lcol_r, col_r;
  logic             add_r, lnew_r;
  logic [CW-1:0]    clr_r;
  logic [CW-1:0]    cstore [DEPTH];
  logic [KW-1:0]    ccount [COLOURS];
  logic [CW-1:0]    srd_r;
  logic [KW-1:0]    crd_raw_r;
  logic [KW-1:0]    cnt;
  logic [AW-1:0]    rd_addr;
  logic             ov_r, oe_r;
  logic [OUT_W-1:0] on_r, od_r;
  logic [NUM_W-1:0] num_r, den_r;
  gcd_req_t         greq;
  gcd_rsp_t         grsp;
  logic             dstart, ddone;
  logic [NUM_W-1:0] qn, qd;
  logic [AW-1:0]    cl, cr, cpos;
  logic [CW-1:0]    ccol;
  logic [AW:0]      len;
  logic [PW:0]      lenprod;

  // clamp bounds and colour into range
  assign cl   = (32'(in_range_left)  > DEPTH - 1) ? AW'(DEPTH - 1) : AW'(in_range_left);
  assign cr   = (32'(in_range_right) > DEPTH - 1) ? AW'(DEPTH - 1) : AW'(in_range_right);
  assign cpos = AW'(in_position);
  assign ccol = (32'(in_colour) > COLOURS - 1) ? CW'(COLOURS - 1) : CW'(in_colour);

  assign cnt  = crd_raw_r;
  assign busy = (st_r != ST_IDLE);

  // pick the next window step: grow first, then shrink
  logic          step_go, step_add;
  logic [AW-1:0] step_pos;
  always_comb begin
    step_go = 1'b1; step_add = 1'b1; step_pos = wlo_r;
    if (wempty_r) begin
      step_go = 1'b0;
    end else if (ql_r < wlo_r) begin
      step_pos = wlo_r - 1'b1;
    end else if (qr_r > whi_r) begin
      step_pos = whi_r + 1'b1;
    end else if (wlo_r < ql_r) begin
      step_add = 1'b0; step_pos = wlo_r;
    end else if (whi_r > qr_r) begin
      step_add = 1'b0; step_pos = whi_r;
    end else begin
      step_go = 1'b0;
    end
  end

  assign rd_addr = (st_r == ST_LOAD) ? lpos_r : pos_r;
  assign len     = {1'b0, qr_r} - {1'b0, ql_r} + 1'b1;
  assign lenprod = (PW + 1)'(len) * (PW + 1)'(len - 1'b1);

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= ST_CLR;
      clr_r    <= '0;
      wempty_r <= 1'b1;
      wlo_r    <= '0;
      whi_r    <= '0;
      pairs_r  <= '0;
      ov_r     <= 1'b0;
    end else begin
      ov_r <= 1'b0;
      case (st_r)
        // zero the count memory one entry per cycle
        ST_CLR: begin
          ccount[clr_r] <= '0;
          clr_r <= clr_r + 1'b1;
          if (clr_r == CW'(COLOURS - 1)) st_r <= ST_IDLE;
        end
        ST_IDLE: begin
          if (start) begin
            if (!in_action) begin
              lpos_r <= cpos; lcol_r <= ccol;
              if (32'(in_position) < DEPTH) begin
                if (!wempty_r && cpos >= wlo_r && cpos <= whi_r) st_r <= ST_LOAD;
                else begin
                  cstore[cpos] <= ccol;
                  st_r <= ST_IDLE;
                end
              end
            end else if (cl >= cr) begin
              ov_r <= 1'b1; on_r <= '0; od_r <= OUT_W'(1); oe_r <= (cl > cr);
            end else begin
              ql_r <= cl; qr_r <= cr;
              if (wempty_r) begin
                wempty_r <= 1'b0; wlo_r <= cl; whi_r <= cl;
                pos_r <= cl; add_r <= 1'b1; st_r <= ST_RD;
              end else begin
                st_r <= ST_PLAN;
              end
            end
          end
        end
        // load inside window: remove old colour, then add new one
        ST_LOAD: begin
          lnew_r <= 1'b0; st_r <= ST_LRD;
        end
        ST_LRD: begin
          st_r <= ST_LUPD;
        end
        ST_LUPD: begin
          if (!lnew_r) begin
            if (cnt != '0) begin
              ccount[col_r] <= cnt - 1'b1;
              pairs_r <= pairs_r - PW'(cnt - 1'b1);
            end
            cstore[lpos_r] <= lcol_r;
            lnew_r <= 1'b1; st_r <= ST_LRD;
          end else begin
            ccount[lcol_r] <= cnt + 1'b1;
            pairs_r <= pairs_r + PW'(cnt);
            st_r <= ST_IDLE;
          end
        end
        ST_PLAN: begin
          if (step_go) begin
            pos_r <= step_pos; add_r <= step_add; st_r <= ST_RD;
          end else st_r <= ST_GCD;
        end
        ST_RD: st_r <= ST_CNT;
        ST_CNT: st_r <= ST_UPD;
        ST_UPD: begin
          if (add_r) begin
            ccount[col_r] <= cnt + 1'b1;
            pairs_r <= pairs_r + PW'(cnt);
          end else if (cnt != '0) begin
            ccount[col_r] <= cnt - 1'b1;
            pairs_r <= pairs_r - PW'(cnt - 1'b1);
          end
          if (pos_r < wlo_r) wlo_r <= pos_r;
          else if (pos_r > whi_r) whi_r <= pos_r;
          else if (!add_r && pos_r == wlo_r) wlo_r <= wlo_r + 1'b1;
          else if (!add_r) whi_r <= whi_r - 1'b1;
          // initial fill walks straight up from ql to qr
          if (add_r && pos_r == wlo_r && pos_r == whi_r && pos_r == ql_r
              && pos_r != qr_r && whi_r < qr_r) begin
            pos_r <= pos_r + 1'b1; whi_r <= pos_r + 1'b1; st_r <= ST_RD;
          end else st_r <= ST_PLAN;
        end
        ST_GCD: begin
          if (grsp.done) st_r <= ST_DIV;
        end
        ST_DIV: begin
          if (ddone) begin
            ov_r <= 1'b1; oe_r <= 1'b0;
            on_r <= qn[OUT_W-1:0]; od_r <= qd[OUT_W-1:0];
            st_r <= ST_IDLE;
          end
        end
        default: st_r <= ST_IDLE;
      endcase
    end
  end

  // memory read ports, registered
  always_ff @(posedge clk) begin
    srd_r     <= cstore[rd_addr];
    crd_raw_r <= ccount[(st_r == ST_LRD && lnew_r) ? lcol_r : srd_r];
    if (st_r == ST_CNT || st_r == ST_LRD) col_r <= srd_r;
  end

  // operand capture for the reduction
  always_ff @(posedge clk) begin
    if (st_r == ST_PLAN && !step_go) begin
      num_r <= NUM_W'(pairs_r);
      den_r <= NUM_W'(lenprod >> 1);
    end
  end

  assign greq.start = (st_r == ST_PLAN) && !step_go;
  assign greq.a     = NUM_W'(pairs_r);
  assign greq.b     = NUM_W'(lenprod >> 1);
  assign dstart     = (st_r == ST_GCD) && grsp.done;

  repc_gcd u_gcd (.clk, .rst_n, .req(greq), .rsp(grsp));

  repc_div u_div (
    .clk, .rst_n, .start(dstart), .num(num_r), .den(den_r),
    .g(grsp.g), .done(ddone), .qn, .qd
  );

  assign out_valid       = ov_r;
  assign out_numerator   = on_r;
  assign out_denominator = od_r;
  assign out_range_error = oe_r;

  // an error result always carries the fraction 0/1
  a_err_frac: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_range_error |-> out_numerator == '0 && out_denominator == 19'd1)
    else $error("error result not 0/1");
  a_win_order: assert property (@(posedge clk) disable iff (!rst_n)
    !wempty_r |-> wlo_r <= whi_r)
    else $error("window inverted");
  a_den_nz: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_denominator != '0)
    else $error("zero denominator");
  a_gcd_busy: assert property (@(posedge clk) disable iff (!rst_n)
    grsp.done |-> st_r == ST_GCD)
    else $error("gcd done outside gcd state");

endmodule

`default_nettype wire

// File: hw/rtl/repc_gcd.sv
// ----------------------------------------------------------------------------
// repc_gcd: bit-serial gcd unit
// Euclid by repeated remainders; each remainder is formed by restoring
// division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module repc_gcd (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire repc_pkg::gcd_req_t req,
  output repc_pkg::gcd_rsp_t      rsp
);
  import repc_pkg::*;

  localparam int unsigned CW = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] a_r, a_nxt, b_r, b_nxt;
  logic [NUM_W-1:0] rem_r, rem_nxt, sh_r, sh_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt, done_r, done_nxt;
  logic [NUM_W:0]   trial;

  // one restoring division step: shift in next dividend bit, subtract if fits
  always_comb begin
    a_nxt = a_r; b_nxt = b_r; rem_nxt = rem_r; sh_nxt = sh_r;
    cnt_nxt = cnt_r; busy_nxt = busy_r; done_nxt = 1'b0;
    trial = {rem_r, sh_r[NUM_W-1]} - {1'b0, b_r};
    if (req.start) begin
      a_nxt = req.a; b_nxt = req.b; rem_nxt = '0; sh_nxt = req.a;
      cnt_nxt = CW'(NUM_W); busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (b_r == '0) begin
        busy_nxt = 1'b0; done_nxt = 1'b1;
      end else if (cnt_r != '0) begin
        sh_nxt = sh_r << 1;
        if (!trial[NUM_W]) rem_nxt = trial[NUM_W-1:0];
        else rem_nxt = {rem_r[NUM_W-2:0], sh_r[NUM_W-1]};
        cnt_nxt = cnt_r - 1'b1;
      end else begin
        a_nxt = b_r; b_nxt = rem_r; sh_nxt = b_r; rem_nxt = '0;
        cnt_nxt = CW'(NUM_W);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    a_r <= a_nxt; b_r <= b_nxt; rem_r <= rem_nxt; sh_r <= sh_nxt; cnt_r <= cnt_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.g    = a_r;

endmodule

`default_nettype wire

// File: hw/rtl/repc_div.sv
// ----------------------------------------------------------------------------
// repc_div: bit-serial exact divider
// Divides numerator and denominator by the gcd together, one bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module repc_div (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire logic [repc_pkg::NUM_W-1:0]  num,
  input  wire logic [repc_pkg::NUM_W-1:0]  den,
  input  wire logic [repc_pkg::NUM_W-1:0]  g,
  output logic                             done,
  output logic [repc_pkg::NUM_W-1:0]       qn,
  output logic [repc_pkg::NUM_W-1:0]       qd
);
  import repc_pkg::*;

  localparam int unsigned CW = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] sn_r, sd_r, rn_r, rd_r, g_r;
  logic [CW-1:0]    cnt_r;
  logic             busy_r, done_r;
  logic [NUM_W:0]   tn, td;

  assign tn = {rn_r, sn_r[NUM_W-1]} - {1'b0, g_r};
  assign td = {rd_r, sd_r[NUM_W-1]} - {1'b0, g_r};

  // shift quotient bits into the dividend registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == '0) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
    if (start) begin
      sn_r <= num; sd_r <= den; rn_r <= '0; rd_r <= '0; g_r <= g;
      cnt_r <= CW'(NUM_W);
    end else if (busy_r && cnt_r != '0) begin
      sn_r <= {sn_r[NUM_W-2:0], ~tn[NUM_W]};
      sd_r <= {sd_r[NUM_W-2:0], ~td[NUM_W]};
      rn_r <= tn[NUM_W] ? {rn_r[NUM_W-2:0], sn_r[NUM_W-1]} : tn[NUM_W-1:0];
      rd_r <= td[NUM_W] ? {rd_r[NUM_W-2:0], sd_r[NUM_W-1]} : td[NUM_W-1:0];
      cnt_r <= cnt_r - 1'b1;
    end
  end

  assign done = done_r;
  assign qn   = sn_r;
  assign qd   = sd_r;

endmodule

`default_nettype wire

// File: sim/range_equal_pair_counter_test.sv
// ----------------------------------------------------------------------------
// range_equal_pair_counter_test: self-checking bench for the pair counter
// Drives loads and range queries through the start/busy handshake with
// random gaps, predicts each reduced fraction from a shadow window and
// histogram, and compares every strobed result with the oldest prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module range_equal_pair_counter_test;

  localparam int unsigned SLOTS      = 1024;
  localparam bit          ACT_LOAD   = 1'b0;
  localparam bit          ACT_QUERY  = 1'b1;
  localparam int          CYCLE_CAP  = 6000000;

  typedef struct {
    logic       action;
    logic [9:0] position;
    logic [9:0] colour;
    logic [9:0] range_left;
    logic [9:0] range_right;
    int         gap;
    bit         drain;
  } item_t;

  typedef struct {
    logic [18:0] numerator;
    logic [18:0] denominator;
    logic        range_error;
  } fraction_t;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic        in_action;
  logic [9:0]  in_position;
  logic [9:0]  in_colour;
  logic [9:0]  in_range_left;
  logic [9:0]  in_range_right;
  logic        out_valid;
  logic [18:0] out_numerator;
  logic [18:0] out_denominator;
  logic        out_range_error;

  item_t     pending_items[$];
  fraction_t pending_fractions[$];
  item_t     cur_item;
  int        hold_cnt;
  int        cycle_cnt;
  bit        failed;

  // shadow state of the block
  logic [9:0]  shadow_colour[SLOTS];
  int unsigned shadow_count[SLOTS];
  int unsigned win_lo;
  int unsigned win_hi;
  bit          win_empty;
  longint unsigned pair_sum;

  range_equal_pair_counter DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_action      (in_action),
    .in_position    (in_position),
    .in_colour      (in_colour),
    .in_range_left  (in_range_left),
    .in_range_right (in_range_right),
    .out_valid      (out_valid),
    .out_numerator  (out_numerator),
    .out_denominator(out_denominator),
    .out_range_error(out_range_error)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // add one position's colour to the window histogram
  function automatic void window_add(int unsigned p);
    int unsigned c;
    c = shadow_colour[p];
    pair_sum += shadow_count[c];
    shadow_count[c]++;
  endfunction

  // drop one position's colour from the window histogram
  function automatic void window_drop(int unsigned p);
    int unsigned c;
    c = shadow_colour[p];
    if (shadow_count[c] != 0) begin
      shadow_count[c]--;
      pair_sum -= shadow_count[c];
    end
  endfunction

  // apply one accepted item and queue the fraction it yields
  function automatic void apply_item(item_t it);
    int unsigned     l;
    int unsigned     r;
    longint unsigned len;
    longint unsigned num;
    longint unsigned den;
    longint unsigned a;
    longint unsigned b;
    longint unsigned t;
    fraction_t       f;
    if (it.action == ACT_LOAD) begin
      if (!win_empty && it.position >= win_lo && it.position <= win_hi) begin
        window_drop(it.position);
        shadow_colour[it.position] = it.colour;
        window_add(it.position);
      end else begin
        shadow_colour[it.position] = it.colour;
      end
      return;
    end
    l = it.range_left;
    r = it.range_right;
    f.numerator = '0;
    f.denominator = 19'd1;
    f.range_error = 1'b0;
    if (l > r) begin
      f.range_error = 1'b1;
    end else if (l < r) begin
      if (win_empty) begin
        for (int unsigned i = l; i <= r; i++) window_add(i);
        win_lo = l;
        win_hi = r;
        win_empty = 1'b0;
      end else begin
        // grow first, then shrink
        while (l < win_lo) begin
          win_lo--;
          window_add(win_lo);
        end
        while (r > win_hi) begin
          win_hi++;
          window_add(win_hi);
        end
        while (win_lo < l) begin
          window_drop(win_lo);
          win_lo++;
        end
        while (win_hi > r) begin
          window_drop(win_hi);
          win_hi--;
        end
      end
      len = r - l + 1;
      num = pair_sum;
      den = len * (len - 1) / 2;
      a = num;
      b = den;
      while (b != 0) begin
        t = a % b;
        a = b;
        b = t;
      end
      if (a == 0) a = 1;
      f.numerator = 19'(num / a);
      f.denominator = 19'(den / a);
    end
    pending_fractions = {pending_fractions, f};
  endfunction

  function automatic void add_item(logic act, int unsigned pos, int unsigned col,
                                   int unsigned l, int unsigned r, int gap, bit drain);
    item_t it;
    it.action = act;
    it.position = 10'(pos);
    it.colour = 10'(col);
    it.range_left = 10'(l);
    it.range_right = 10'(r);
    it.gap = gap;
    it.drain = drain;
    pending_items = {pending_items, it};
  endfunction

  // driver: present items, hold them until taken, then idle the drawn gap; a drain item waits for all results
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
      hold_cnt <= 0;
    end else if (start && !busy) begin
      apply_item(cur_item);
      if (pending_items.size() > 0 && pending_items[0].gap == 0 && !pending_items[0].drain)
      begin
        cur_item = pending_items.pop_front();
        in_action <= cur_item.action;
        in_position <= cur_item.position;
        in_colour <= cur_item.colour;
        in_range_left <= cur_item.range_left;
        in_range_right <= cur_item.range_right;
      end else begin
        start <= 1'b0;
        hold_cnt <= (pending_items.size() > 0) ? pending_items[0].gap : 0;
      end
    end else if (!start) begin
      if (hold_cnt != 0) begin
        hold_cnt <= hold_cnt - 1;
      end else if (pending_items.size() > 0 &&
                   (!pending_items[0].drain || pending_fractions.size() == 0)) begin
        cur_item = pending_items.pop_front();
        in_action <= cur_item.action;
        in_position <= cur_item.position;
        in_colour <= cur_item.colour;
        in_range_left <= cur_item.range_left;
        in_range_right <= cur_item.range_right;
        start <= 1'b1;
      end
    end
  end

  // monitor: compare each strobed result with the oldest prediction
  always @(posedge clk) begin
    fraction_t f;
    if (rst_n && out_valid) begin
      if (pending_fractions.size() == 0) begin
        $error("unexpected result %0d/%0d err %0b", out_numerator, out_denominator,
               out_range_error);
        failed = 1'b1;
      end else begin
        f = pending_fractions.pop_front();
        if (out_numerator !== f.numerator) begin
          $error("numerator expected %0d actual %0d", f.numerator, out_numerator);
          failed = 1'b1;
        end
        if (out_denominator !== f.denominator) begin
          $error("denominator expected %0d actual %0d", f.denominator, out_denominator);
          failed = 1'b1;
        end
        if (out_range_error !== f.range_error) begin
          $error("range_error expected %0b actual %0b", f.range_error, out_range_error);
          failed = 1'b1;
        end
      end
    end
  end

  // timeout
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_CAP) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    int unsigned base;
    int unsigned gl;
    int unsigned gr;
    int unsigned l;
    int unsigned r;
    int unsigned pos;
    int unsigned col;
    int          pick;
    int          gap;
    int          lo_off;
    int          hi_off;
    failed = 1'b0;
    cycle_cnt = 0;
    rst_n = 1'b0;
    start = 1'b0;
    in_action = 1'b0;
    in_position = '0;
    in_colour = '0;
    in_range_left = '0;
    in_range_right = '0;
    hold_cnt = 0;
    for (int i = 0; i < SLOTS; i++) begin
      shadow_colour[i] = '0;
      shadow_count[i] = 0;
    end
    win_lo = 0;
    win_hi = 0;
    win_empty = 1'b1;
    pair_sum = 0;

    // directed: extremes, equal pair at the top, in-window reload, errors
    add_item(ACT_LOAD, 1023, 1023, 0, 0, 0, 0);
    add_item(ACT_LOAD, 1022, 1023, 0, 0, 0, 0);
    add_item(ACT_LOAD, 0, 0, 0, 0, 3, 0);
    add_item(ACT_QUERY, 0, 0, 1022, 1023, 0, 0);
    add_item(ACT_QUERY, 0, 0, 0, 0, 0, 0);
    add_item(ACT_QUERY, 0, 0, 1023, 1023, 2, 0);
    add_item(ACT_QUERY, 0, 0, 1023, 0, 0, 0);
    add_item(ACT_QUERY, 0, 0, 1, 0, 0, 0);
    add_item(ACT_LOAD, 1023, 5, 0, 0, 0, 0);
    add_item(ACT_QUERY, 0, 0, 1022, 1023, 0, 0);
    add_item(ACT_LOAD, 1021, 5, 0, 0, 1, 0);
    add_item(ACT_QUERY, 0, 0, 1021, 1023, 0, 0);
    add_item(ACT_LOAD, 1020, 1023, 0, 0, 0, 0);
    add_item(ACT_QUERY, 0, 0, 1020, 1022, 0, 0);
    add_item(ACT_QUERY, 0, 0, 1021, 1023, 0, 0);
    base = 1020;
    gl = 1021;
    gr = 1023;

    // random: the written region grows down from the top, queries stay near it
    for (int i = 0; i < 890; i++) begin
      gap = ((i / 50) % 4 == 0) ? 0 : $urandom_range(0, 11);
      pick = $urandom_range(0, 99);
      col = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 3) : $urandom_range(0, 1023);
      if (pick < 35) begin
        pick = $urandom_range(0, 9);
        if (pick < 4 && base > 0) begin
          base--;
          pos = base;
        end else if (pick < 7) begin
          pos = $urandom_range(base, 1023);
        end else begin
          pos = $urandom_range(0, 1023);
        end
        add_item(ACT_LOAD, pos, col, $urandom_range(0, 1023), $urandom_range(0, 1023),
                 gap, i == 400);
      end else if (pick < 40) begin
        l = $urandom_range(1, 1023);
        r = $urandom_range(0, l - 1);
        add_item(ACT_QUERY, $urandom_range(0, 1023), col, l, r, gap, i == 400);
      end else if (pick < 44) begin
        l = $urandom_range(0, 1023);
        add_item(ACT_QUERY, $urandom_range(0, 1023), col, l, l, gap, i == 400);
      end else begin
        if ($urandom_range(0, 19) == 0) begin
          l = base;
          r = 1023;
        end else begin
          lo_off = int'(gl) + int'($urandom_range(0, 12)) - 6;
          if (lo_off < int'(base)) lo_off = base;
          if (lo_off > 1022) lo_off = 1022;
          l = lo_off;
          hi_off = int'(gr) + int'($urandom_range(0, 12)) - 6;
          if (hi_off <= int'(l)) hi_off = l + 1;
          if (hi_off > 1023) hi_off = 1023;
          r = hi_off;
        end
        gl = l;
        gr = r;
        add_item(ACT_QUERY, $urandom_range(0, 1023), col, l, r, gap, i == 400);
      end
    end

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // wait for all items taken and all fractions seen, then let the block settle
    while (pending_items.size() > 0 || start || pending_fractions.size() > 0)
      @(posedge clk);
    repeat (40) @(posedge clk);
    if (!failed && pending_fractions.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: filelist.f
hw/rtl/repc_pkg.sv
hw/rtl/repc_gcd.sv
hw/rtl/repc_div.sv
hw/rtl/range_equal_pair_counter.sv
sim/range_equal_pair_counter_test.sv
